[src/uart_buffered_queue_controller_core_macros.svh]
// Assertion macros shared by the queue controller RTL.
`ifndef UART_BUFFERED_QUEUE_CONTROLLER_CORE_MACROS_SVH
`define UART_BUFFERED_QUEUE_CONTROLLER_CORE_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define UBQC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UBQC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/ubqc_pkg.sv]
// Types and constants shared by the queue controller.
`default_nettype none

package ubqc_pkg;

  localparam int QueueDepthDef = 64;
  localparam int CapRegW       = 7;
  localparam int CapResetVal   = 64;
  localparam int CountW        = 7;

  // Register indexes on the config port
  localparam logic RegRxCap = 1'b0;
  localparam logic RegTxCap = 1'b1;

  // Item kinds
  localparam logic [1:0] KindSend  = 2'd0;
  localparam logic [1:0] KindRecv  = 2'd1;
  localparam logic [1:0] KindEvent = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_of_call;
    logic       rx_done;
    logic       tx_done;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              read_valid;
    logic [7:0]        read_byte;
    logic [CountW-1:0] rx_count;
    logic [CountW-1:0] tx_count;
    logic              tx_busy;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic push_tx;
    logic push_rx;
    logic rd;
    logic tx_start;
    logic tx_next;
    logic pop_rx;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       last_of_call;
    logic       rx_done;
    logic       tx_done;
    logic       sending;
    logic       out_stall;
  } status_t;

endpackage

`default_nettype wire

[src/ubqc_item_if.sv]
// Input item channel: valid/ready with one item per beat.
`default_nettype none

interface ubqc_item_if;
  logic            valid;
  logic            ready;
  ubqc_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/ubqc_result_if.sv]
// Result channel: valid/ready with one result per beat.
`default_nettype none

interface ubqc_result_if;
  logic              valid;
  logic              ready;
  ubqc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/ubqc_ring.sv]
// Byte ring queue with capacity register, overwrite-oldest push and registered read.
`default_nettype none

`include "uart_buffered_queue_controller_core_macros.svh"

module ubqc_ring #(
  parameter int QUEUE_DEPTH = ubqc_pkg::QueueDepthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               clr_i,
  input  wire logic [ubqc_pkg::CapRegW-1:0]       cap_i,
  input  wire logic                               push_i,
  input  wire logic [7:0]                         push_data_i,
  input  wire logic                               rd_i,
  input  wire logic                               pop_i,
  output logic [7:0]                              rd_data_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        fill_o,
  output logic                                    empty_o
);
  import ubqc_pkg::*;

  localparam int IdxW   = $clog2(QUEUE_DEPTH);
  localparam int CapW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW   = CapW + 1;
  localparam int CapRst = (CapResetVal > QUEUE_DEPTH) ? QUEUE_DEPTH : CapResetVal;

  logic [7:0]      mem_q [QUEUE_DEPTH];
  logic [7:0]      rd_data_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [CapW-1:0] fill_q, fill_d;
  logic [CapW-1:0] cap_q, cap_d;

  logic [SumW-1:0] tail_sum, tail_wrap, head_inc;
  logic [IdxW-1:0] tail_idx, head_wrap;
  logic [7:0]      cap_ext;

  // Clamp written capacity to 1..QUEUE_DEPTH
  always_comb begin
    cap_ext = {1'b0, cap_i};
    if (cap_ext == 8'd0) begin
      cap_d = CapW'(1);
    end else if (cap_ext > 8'(QUEUE_DEPTH)) begin
      cap_d = CapW'(QUEUE_DEPTH);
    end else begin
      cap_d = CapW'(cap_ext);
    end
  end

  always_comb begin
    tail_sum  = SumW'(head_q) + SumW'(fill_q);
    tail_wrap = (tail_sum >= SumW'(cap_q)) ? tail_sum - SumW'(cap_q) : tail_sum;
    tail_idx  = tail_wrap[IdxW-1:0];
    head_inc  = SumW'(head_q) + SumW'(1);
    head_wrap = (head_inc >= SumW'(cap_q)) ? '0 : head_inc[IdxW-1:0];
  end

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (push_i) begin
      if (fill_q < cap_q) begin
        fill_d = fill_q + CapW'(1);
      end else begin
        head_d = head_wrap;
      end
    end else if (pop_i && (fill_q != '0)) begin
      head_d = head_wrap;
      fill_d = fill_q - CapW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      cap_q  <= CapW'(CapRst);
    end else if (clr_i) begin
      head_q <= '0;
      fill_q <= '0;
      cap_q  <= cap_d;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_idx] <= push_data_i;
    end
    if (rd_i) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  assign rd_data_o = rd_data_q;
  assign fill_o    = fill_d;
  assign empty_o   = (fill_q == '0);

  `UBQC_ASSERT(a_fill_le_cap, clk_i, rst_ni, fill_q <= cap_q, "ring fill above capacity")
  `UBQC_ASSERT(a_head_lt_cap, clk_i, rst_ni, SumW'(head_q) < SumW'(cap_q), "ring head out of range")
  `UBQC_ASSERT(a_push_pop_excl, clk_i, rst_ni, !(push_i && pop_i), "push and pop in one cycle")

endmodule

`default_nettype wire

[src/ubqc_datapath.sv]
// Datapath: item latch, both ring queues, busy flag and result register.
`default_nettype none

module ubqc_datapath #(
  parameter int QUEUE_DEPTH = ubqc_pkg::QueueDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [ubqc_pkg::CapRegW-1:0] cfg_data_i,
  input  wire ubqc_pkg::item_t              item_i,
  input  wire ubqc_pkg::cmd_t               cmd_i,
  output ubqc_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output ubqc_pkg::result_t                 out_data_o
);
  import ubqc_pkg::*;

  localparam int CapW = $clog2(QUEUE_DEPTH + 1);

  item_t   item_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    sending_q, sending_d;

  logic [7:0]      tx_rd_data, rx_rd_data;
  logic [CapW-1:0] tx_fill, rx_fill;
  logic            tx_empty, rx_empty;
  logic            pop_tx;
  logic            tx_got, rx_got;

  assign pop_tx = cmd_i.tx_start || cmd_i.tx_next;

  ubqc_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tx_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (cfg_we_i && (cfg_idx_i == RegTxCap)),
    .cap_i       (cfg_data_i),
    .push_i      (cmd_i.push_tx),
    .push_data_i (item_q.data_byte),
    .rd_i        (cmd_i.rd),
    .pop_i       (pop_tx),
    .rd_data_o   (tx_rd_data),
    .fill_o      (tx_fill),
    .empty_o     (tx_empty)
  );

  ubqc_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rx_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (cfg_we_i && (cfg_idx_i == RegRxCap)),
    .cap_i       (cfg_data_i),
    .push_i      (cmd_i.push_rx),
    .push_data_i (item_q.rx_byte),
    .rd_i        (cmd_i.rd),
    .pop_i       (cmd_i.pop_rx),
    .rd_data_o   (rx_rd_data),
    .fill_o      (rx_fill),
    .empty_o     (rx_empty)
  );

  always_comb begin
    tx_got = pop_tx && !tx_empty;
    rx_got = cmd_i.pop_rx && !rx_empty;

    sending_d = sending_q;
    if (cmd_i.tx_start) begin
      sending_d = 1'b1;
    end else if (cmd_i.tx_next && tx_empty) begin
      sending_d = 1'b0;
    end

    res_d.tx_valid   = tx_got;
    res_d.tx_byte    = tx_got ? tx_rd_data : 8'd0;
    res_d.read_valid = rx_got;
    res_d.read_byte  = rx_got ? rx_rd_data : 8'd0;
    res_d.rx_count   = CountW'(rx_fill);
    res_d.tx_count   = CountW'(tx_fill);
    res_d.tx_busy    = sending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sending_q <= sending_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
    if (cmd_i.load_out) begin
      res_q <= res_d;
    end
  end

  assign status_o.kind         = item_q.kind;
  assign status_o.last_of_call = item_q.last_of_call;
  assign status_o.rx_done      = item_q.rx_done;
  assign status_o.tx_done      = item_q.tx_done;
  assign status_o.sending      = sending_q;
  assign status_o.out_stall    = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

[src/ubqc_ctrl.sv]
// Controller: sequences latch, push, store read and pop for each item.
`default_nettype none

`include "uart_buffered_queue_controller_core_macros.svh"

module ubqc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ubqc_pkg::status_t status_i,
  output ubqc_pkg::cmd_t         cmd_o
);
  import ubqc_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StPush,
    StRead,
    StPop
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = StPush;
        end
      end
      StPush: begin
        cmd_o.push_tx = (status_i.kind == KindSend);
        cmd_o.push_rx = (status_i.kind == KindEvent) && status_i.rx_done;
        state_d       = StRead;
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StPop;
      end
      StPop: begin
        // hold until the result register is free
        if (!status_i.out_stall) begin
          cmd_o.tx_start = (status_i.kind == KindSend) && status_i.last_of_call &&
                           !status_i.sending;
          cmd_o.tx_next  = (status_i.kind == KindEvent) && status_i.tx_done &&
                           status_i.sending;
          cmd_o.pop_rx   = (status_i.kind == KindRecv);
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `UBQC_ASSERT_NEXT(a_accept_to_push, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == StPush, "accepted beat did not start push")
  `UBQC_ASSERT(a_load_not_stalled, clk_i, rst_ni, !(cmd_o.load_out && status_i.out_stall), "result loaded over a waiting beat")
  `UBQC_ASSERT_NEXT(a_pop_done_idle, clk_i, rst_ni, cmd_o.load_out, state_q == StIdle, "controller did not return to idle")

endmodule

`default_nettype wire

[src/uart_buffered_queue_controller_core.sv]
// Top level of the buffered UART queue controller.
//
// item_i takes one beat per host send, host receive or line interrupt event;
// result_o gives exactly one beat per accepted item, in order. Both channels
// use valid/ready. Capacities are written on cfg_we_i/cfg_idx_i/cfg_data_i
// (index 0 receive, index 1 transmit); a write empties that queue and takes
// effect at once. Write only while no item is in flight.
// An accepted item beat is latched and then takes the push, store read and
// pop steps through the single-ported byte stores; its result beat is loaded
// at the pop step, and the next item is accepted only after that step.
// If result_o is stalled, the next item is still accepted and runs up to its
// pop step, where it waits until the held result beat is taken.
// Reset: both queues empty, capacities 64 (or QUEUE_DEPTH if smaller), no
// transmission chain running; store contents are undefined and never read
// before written. No clearing pass is needed.
`default_nettype none

module uart_buffered_queue_controller_core #(
  parameter int QUEUE_DEPTH = ubqc_pkg::QueueDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [ubqc_pkg::CapRegW-1:0] cfg_data_i,
  ubqc_item_if.sink                         item_i,
  ubqc_result_if.source                     result_o
);
  import ubqc_pkg::*;

  cmd_t    cmd;
  status_t status;

  ubqc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ubqc_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (result_o.data)
  );

endmodule

`default_nettype wire

[test/testbench.sv]
// Testbench for the buffered UART queue controller: directed and random beats checked by a model.
`timescale 1ns / 100ps

module testbench;
  import ubqc_pkg::*;

  // Kind 3 has no name in the package; the block reports only counts and the busy flag.
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int PhaseItems = 175;
  localparam int StuckLimit = 4000;

  // Ring queue model plus the expected result beats, oldest first.
  class queue_checker;
    localparam int RxQ = 0;
    localparam int TxQ = 1;
    localparam int Depth = QueueDepthDef;

    logic [7:0] mem [2][Depth];
    int         head [2];
    int         fill [2];
    int         cap [2];
    bit         sending;
    result_t    pending_results [$];
    int         errors;

    function new();
      for (int q = 0; q < 2; q++) begin
        for (int i = 0; i < Depth; i++) mem[q][i] = '0;
        head[q] = 0;
        fill[q] = 0;
        cap[q]  = (CapResetVal > Depth) ? Depth : CapResetVal;
      end
      sending = 1'b0;
      errors  = 0;
    endfunction

    // Out-of-range values saturate into 1..Depth; a write empties the queue.
    function void write_cap(logic idx, logic [CapRegW-1:0] v);
      int q;
      q = (idx == RegTxCap) ? TxQ : RxQ;
      if (v == 0) cap[q] = 1;
      else if (v > Depth) cap[q] = Depth;
      else cap[q] = int'(v);
      head[q] = 0;
      fill[q] = 0;
    endfunction

    function void push(int q, logic [7:0] b);
      int tail;
      tail = head[q] + fill[q];
      if (tail >= cap[q]) tail -= cap[q];
      mem[q][tail] = b;
      if (fill[q] < cap[q]) begin
        fill[q]++;
      end else begin
        // full: oldest byte dropped
        head[q]++;
        if (head[q] >= cap[q]) head[q] = 0;
      end
    endfunction

    function bit pop(int q, output logic [7:0] b);
      b = '0;
      if (fill[q] == 0) return 1'b0;
      b = mem[q][head[q]];
      head[q]++;
      if (head[q] >= cap[q]) head[q] = 0;
      fill[q]--;
      return 1'b1;
    endfunction

    function void note_item(item_t it);
      result_t    r;
      logic [7:0] b;
      r = '0;
      case (it.kind)
        KindSend: begin
          push(TxQ, it.data_byte);
          if (it.last_of_call && !sending) begin
            r.tx_valid = pop(TxQ, b);
            r.tx_byte  = b;
            sending    = 1'b1;
          end
        end
        KindRecv: begin
          r.read_valid = pop(RxQ, b);
          r.read_byte  = b;
        end
        KindEvent: begin
          // received byte goes in before the transmit-done is handled
          if (it.rx_done) push(RxQ, it.rx_byte);
          if (it.tx_done && sending) begin
            r.tx_valid = pop(TxQ, b);
            r.tx_byte  = b;
            if (!r.tx_valid) sending = 1'b0;
          end
        end
        default: ;
      endcase
      r.rx_count = CountW'(fill[RxQ]);
      r.tx_count = CountW'(fill[TxQ]);
      r.tx_busy  = sending;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", got));
        return;
      end
      want = pending_results.pop_front();
      compare("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
      compare("tx_byte", got.tx_byte, want.tx_byte);
      compare("read_valid", 8'(got.read_valid), 8'(want.read_valid));
      compare("read_byte", got.read_byte, want.read_byte);
      compare("rx_count", 8'(got.rx_count), 8'(want.rx_count));
      compare("tx_count", 8'(got.tx_count), 8'(want.tx_count));
      compare("tx_busy", 8'(got.tx_busy), 8'(want.tx_busy));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_idx;
  logic [CapRegW-1:0] cfg_data;
  logic               rsp_hold;
  int                 send_idle_pct;
  int                 rsp_stall_pct;
  int                 stuck_cycles;

  ubqc_item_if   item_bus ();
  ubqc_result_if result_bus ();

  queue_checker queues = new();

  uart_buffered_queue_controller_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each beat, then pick ready for the next edge.
  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) queues.check_result(result_bus.data);
    result_bus.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic item_t item_of(logic [1:0] kind, logic [7:0] data, logic last,
                                    logic rxd, logic txd, logic [7:0] rxb);
    item_t it;
    it.kind         = kind;
    it.data_byte    = data;
    it.last_of_call = last;
    it.rx_done      = rxd;
    it.tx_done      = txd;
    it.rx_byte      = rxb;
    return it;
  endfunction

  // Mostly send calls, host reads and line events; ignored fields stay random.
  function automatic item_t random_item();
    item_t it;
    int    pick;
    it = item_of(KindUnused, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 36) begin
      it.kind         = KindSend;
      it.last_of_call = ($urandom_range(3) == 0);
    end else if (pick < 60) begin
      it.kind = KindRecv;
    end else if (pick < 96) begin
      it.kind    = KindEvent;
      it.rx_done = ($urandom_range(99) < 60);
      it.tx_done = ($urandom_range(99) < 55);
    end
    return it;
  endfunction

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.data  <= it;
    do @(posedge clk); while (!item_bus.ready);
    queues.note_item(it);
  endtask

  task automatic drain();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (queues.pending_results.size() != 0);
  endtask

  task automatic set_caps(logic [CapRegW-1:0] rx_cap, logic [CapRegW-1:0] tx_cap);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegRxCap;
    cfg_data <= rx_cap;
    @(posedge clk);
    queues.write_cap(RegRxCap, rx_cap);
    cfg_idx  <= RegTxCap;
    cfg_data <= tx_cap;
    @(posedge clk);
    queues.write_cap(RegTxCap, tx_cap);
    cfg_we <= 1'b0;
  endtask

  // Result side held off for a while, counted in its own thread.
  task automatic hold_results(int cycles);
    rsp_hold <= 1'b1;
    fork
      begin
        repeat (cycles) @(posedge clk);
        rsp_hold <= 1'b0;
      end
    join_none
  endtask

  logic [CapRegW-1:0] rx_caps [8] = '{7'd64, 7'd1, 7'd0, 7'd7, 7'd65, 7'd16, 7'd2, 7'd127};
  logic [CapRegW-1:0] tx_caps [8] = '{7'd64, 7'd1, 7'd127, 7'd3, 7'd2, 7'd64, 7'd33, 7'd0};
  int                 idle_pcts [4] = '{0, 75, 0, 18};
  int                 stall_pcts [4] = '{0, 0, 75, 18};

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = RegRxCap;
    cfg_data         = '0;
    rsp_hold         = 1'b0;
    send_idle_pct    = 0;
    rsp_stall_pct    = 0;
    item_bus.valid   = 1'b0;
    item_bus.data    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacities: empty reads, idle events, start and end of a chain
    send_item(item_of(KindRecv, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF));
    send_item(item_of(KindEvent, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00));
    send_item(item_of(KindUnused, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF));
    send_item(item_of(KindSend, 8'h00, 1'b0, 1'b1, 1'b1, 8'hFF));
    send_item(item_of(KindSend, 8'hFF, 1'b1, 1'b0, 1'b0, 8'h00));
    send_item(item_of(KindSend, 8'h5A, 1'b1, 1'b0, 1'b0, 8'h00));
    send_item(item_of(KindEvent, 8'h00, 1'b0, 1'b1, 1'b1, 8'hFF));
    send_item(item_of(KindEvent, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00));
    send_item(item_of(KindEvent, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00));
    send_item(item_of(KindRecv, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(item_of(KindEvent, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00));
    send_item(item_of(KindRecv, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));

    // single-byte queues: overwrite on both sides
    drain();
    set_caps(7'd1, 7'd1);
    send_item(item_of(KindEvent, 8'h00, 1'b0, 1'b1, 1'b0, 8'hA5));
    send_item(item_of(KindEvent, 8'h00, 1'b0, 1'b1, 1'b0, 8'h5A));
    send_item(item_of(KindRecv, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(item_of(KindRecv, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(item_of(KindSend, 8'h11, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(item_of(KindSend, 8'h22, 1'b1, 1'b0, 1'b0, 8'h00));
    send_item(item_of(KindSend, 8'h33, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(item_of(KindSend, 8'h44, 1'b0, 1'b0, 1'b0, 8'h00));
    send_item(item_of(KindEvent, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00));
    send_item(item_of(KindEvent, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00));

    // back-pressure: results held while items keep coming, then a full drain
    drain();
    hold_results(300);
    repeat (40) send_item(random_item());
    drain();

    for (int p = 0; p < 8; p++) begin
      drain();
      set_caps(rx_caps[p], tx_caps[p]);
      send_idle_pct = idle_pcts[p % 4];
      rsp_stall_pct = stall_pcts[p % 4];
      repeat (PhaseItems) send_item(random_item());
    end

    drain();
    repeat (12) @(posedge clk);
    if (queues.errors == 0 && queues.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
